/* hdl/qds_pkg.sv */
// shared types and constants for the quadrature decoder with speed estimate
`default_nettype none
package qds_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CPR_W  = 16;
	localparam int unsigned PROD_W = DATA_W + CPR_W;

	// command codes carried by the cmd field
	localparam logic [1:0] CMD_EDGE_A = 2'd0;
	localparam logic [1:0] CMD_EDGE_B = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;
	localparam logic [1:0] CMD_SET    = 2'd3;

	// degrees per revolution times ticks per second
	localparam logic [PROD_W-1:0] SPEED_DIVIDEND = PROD_W'(360000000);
	localparam logic [CPR_W-1:0]  RESET_COUNTS   = CPR_W'(2400);
	localparam logic [PROD_W-1:0] FILTER_DIVISOR = PROD_W'(5);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAP,
		ST_DIVF,
		ST_MUL,
		ST_SPD,
		ST_DIVS,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

/* hdl/qds_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module qds_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [qds_pkg::CPR_W-1:0]   op_a,
	input  wire logic [qds_pkg::DATA_W-1:0]  op_b,
	output logic [qds_pkg::PROD_W-1:0]       product,
	output logic                             done
);

	logic [qds_pkg::PROD_W-1:0] acc_q;
	logic [qds_pkg::PROD_W-1:0] mcand_q;
	logic [qds_pkg::CPR_W-1:0]  mplier_q;
	logic [$clog2(qds_pkg::CPR_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(qds_pkg::CPR_W)'(qds_pkg::CPR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {{qds_pkg::CPR_W{1'b0}}, op_b};
			mplier_q <= op_a;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[qds_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[qds_pkg::CPR_W-1:1]};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule
`default_nettype wire

/* hdl/qds_div.sv */
// restoring divider, one quotient bit per cycle, shared by filter and speed
`default_nettype none
module qds_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [qds_pkg::PROD_W-1:0]  rem_init,
	input  wire logic [qds_pkg::DATA_W-1:0]  dividend_lo,
	input  wire logic [qds_pkg::PROD_W-1:0]  divisor,
	output logic [qds_pkg::DATA_W-1:0]       quotient,
	output logic                             done
);

	logic [qds_pkg::PROD_W-1:0] rem_q;
	logic [qds_pkg::DATA_W-1:0] quo_q;
	logic [qds_pkg::PROD_W-1:0] dvs_q;
	logic [$clog2(qds_pkg::DATA_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [qds_pkg::PROD_W:0] trial;
	logic [qds_pkg::PROD_W:0] diff;

	// remainder stays below the divisor, so the trial fits one extra bit
	assign trial = {rem_q, quo_q[qds_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(qds_pkg::DATA_W)'(qds_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= dividend_lo;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[qds_pkg::PROD_W]) begin
				rem_q <= diff[qds_pkg::PROD_W-1:0];
			end else begin
				rem_q <= trial[qds_pkg::PROD_W-1:0];
			end
			quo_q <= {quo_q[qds_pkg::DATA_W-2:0], ~diff[qds_pkg::PROD_W]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

/* hdl/quadrature_decoder_speed.sv */
// top level: quadrature position counter, edge spacing filter and speed sampler
//
// Each request yields one result, loaded into the output register. A set position
// request goes straight to the result. An edge request runs the 32-step serial
// divide by five of the spacing filter. A speed update runs a 16-step shift-add
// multiply of counts per revolution by the filtered period, then a 32-step serial
// divide, both units one bit per cycle. When no edge is recent enough, or the
// divisor is zero, the divide is skipped. One request is in work at a time. A
// finished result sits in the output register while the next request is taken. A
// stalled output holds back the next result, and the input stays stalled until
// that result is loaded.
`default_nettype none
module quadrature_decoder_speed (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [qds_pkg::CPR_W-1:0]         cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        cmd,
	input  wire logic [qds_pkg::DATA_W-1:0]        timestamp,
	input  wire logic                              level_a,
	input  wire logic                              level_b,
	input  wire logic signed [qds_pkg::DATA_W-1:0] new_position,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [qds_pkg::DATA_W-1:0]      position_out,
	output logic signed [qds_pkg::DATA_W-1:0]      delta_position,
	output logic [qds_pkg::DATA_W-1:0]             speed_out,
	output logic [qds_pkg::DATA_W-1:0]             period_out
);

	qds_pkg::state_t state_q, state_nxt;

	logic [qds_pkg::CPR_W-1:0]  cpr_q;
	logic [qds_pkg::DATA_W-1:0] count_q;
	logic [qds_pkg::DATA_W-1:0] time_a_q;
	logic [qds_pkg::DATA_W-1:0] time_b_q;
	logic [qds_pkg::DATA_W-1:0] period_q;
	logic [qds_pkg::DATA_W-1:0] count_upd_q;
	logic [qds_pkg::DATA_W-1:0] time_upd_q;
	logic [qds_pkg::DATA_W-1:0] speed_q;
	logic [qds_pkg::DATA_W-1:0] delta_q;
	logic                       recent_q;
	logic                       out_valid_q;

	logic accept;
	logic mul_start, mul_done, div_start, div_done, out_load, spd_go;
	logic up;
	logic [qds_pkg::PROD_W-1:0] product;
	logic [qds_pkg::PROD_W-1:0] speed_num;
	logic [qds_pkg::DATA_W-1:0] gap;
	logic [qds_pkg::DATA_W-1:0] filt_sum;
	logic [qds_pkg::DATA_W-1:0] quotient;
	logic [qds_pkg::DATA_W-1:0] since_a, since_b, interval;
	logic                       recent;
	logic [qds_pkg::PROD_W-1:0] div_rem_init;
	logic [qds_pkg::DATA_W-1:0] div_lo;
	logic [qds_pkg::PROD_W-1:0] div_divisor;

	assign accept = in_valid && !in_stall;

	// x4 direction rules
	always_comb begin
		if (cmd == qds_pkg::CMD_EDGE_A) begin
			up = level_a ? !level_b : level_b;
		end else begin
			up = level_b ? level_a : !level_a;
		end
	end

	// an edge on either channel within twice the time since the last update
	assign since_a  = timestamp - time_a_q;
	assign since_b  = timestamp - time_b_q;
	assign interval = timestamp - time_upd_q;
	assign recent   = ({1'b0, since_a} < {interval, 1'b0})
		|| ({1'b0, since_b} < {interval, 1'b0});

	assign gap = (time_a_q > time_b_q) ? time_a_q - time_b_q : time_b_q - time_a_q;
	assign filt_sum = {period_q[qds_pkg::DATA_W-3:0], 2'b00} + gap;

	assign speed_num = qds_pkg::SPEED_DIVIDEND + {1'b0, product[qds_pkg::PROD_W-1:1]};
	assign spd_go    = recent_q && (product != '0);

	always_comb begin
		if (state_q == qds_pkg::ST_GAP) begin
			div_rem_init = '0;
			div_lo       = filt_sum;
			div_divisor  = qds_pkg::FILTER_DIVISOR;
		end else begin
			// quotient fits 32 bits, so the top of the dividend seeds the remainder
			div_rem_init = {{qds_pkg::DATA_W{1'b0}},
				speed_num[qds_pkg::PROD_W-1:qds_pkg::DATA_W]};
			div_lo       = speed_num[qds_pkg::DATA_W-1:0];
			div_divisor  = product;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			qds_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd)
						qds_pkg::CMD_EDGE_A, qds_pkg::CMD_EDGE_B: state_nxt = qds_pkg::ST_GAP;
						qds_pkg::CMD_UPDATE: state_nxt = qds_pkg::ST_MUL;
						default: state_nxt = qds_pkg::ST_RESULT;
					endcase
				end
			end
			qds_pkg::ST_GAP: state_nxt = qds_pkg::ST_DIVF;
			qds_pkg::ST_DIVF: begin
				if (div_done) state_nxt = qds_pkg::ST_RESULT;
			end
			qds_pkg::ST_MUL: begin
				if (mul_done) state_nxt = qds_pkg::ST_SPD;
			end
			qds_pkg::ST_SPD: state_nxt = spd_go ? qds_pkg::ST_DIVS : qds_pkg::ST_RESULT;
			qds_pkg::ST_DIVS: begin
				if (div_done) state_nxt = qds_pkg::ST_RESULT;
			end
			qds_pkg::ST_RESULT: begin
				if (out_load) state_nxt = qds_pkg::ST_IDLE;
			end
			default: state_nxt = qds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != qds_pkg::ST_IDLE);
		mul_start = (state_q == qds_pkg::ST_IDLE) && in_valid && (cmd == qds_pkg::CMD_UPDATE);
		div_start = (state_q == qds_pkg::ST_GAP) || ((state_q == qds_pkg::ST_SPD) && spd_go);
		out_load  = (state_q == qds_pkg::ST_RESULT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qds_pkg::ST_IDLE;
			cpr_q       <= qds_pkg::RESET_COUNTS;
			count_q     <= '0;
			time_a_q    <= '0;
			time_b_q    <= '0;
			period_q    <= '0;
			count_upd_q <= '0;
			time_upd_q  <= '0;
			speed_q     <= '0;
			delta_q     <= '0;
			recent_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				cpr_q <= cfg_wr_data;
			end
			if (accept) begin
				case (cmd)
					qds_pkg::CMD_EDGE_A, qds_pkg::CMD_EDGE_B: begin
						delta_q <= '0;
						count_q <= up ? count_q + 1'b1 : count_q - 1'b1;
						if (cmd == qds_pkg::CMD_EDGE_A) begin
							time_a_q <= timestamp;
						end else begin
							time_b_q <= timestamp;
						end
					end
					qds_pkg::CMD_UPDATE: begin
						delta_q     <= count_q - count_upd_q;
						recent_q    <= recent;
						count_upd_q <= count_q;
						time_upd_q  <= timestamp;
					end
					default: begin
						delta_q     <= '0;
						count_q     <= new_position;
						count_upd_q <= new_position;
					end
				endcase
			end
			if (state_q == qds_pkg::ST_DIVF && div_done) begin
				period_q <= quotient;
			end
			if (state_q == qds_pkg::ST_SPD && !spd_go) begin
				speed_q <= '0;
			end
			if (state_q == qds_pkg::ST_DIVS && div_done) begin
				speed_q <= quotient;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			position_out   <= count_q;
			delta_position <= delta_q;
			speed_out      <= speed_q;
			period_out     <= period_q;
		end
	end

	assign out_valid = out_valid_q;

	qds_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (cpr_q),
		.op_b    (period_q),
		.product (product),
		.done    (mul_done)
	);

	qds_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.rem_init    (div_rem_init),
		.dividend_lo (div_lo),
		.divisor     (div_divisor),
		.quotient    (quotient),
		.done        (div_done)
	);

endmodule
`default_nettype wire

/* hdl/qds_checker.sv */
// port-level checks for the quadrature decoder, bound to the top level
`default_nettype none
module qds_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [1:0]                        cmd,
	input  wire logic signed [qds_pkg::DATA_W-1:0] new_position,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic signed [qds_pkg::DATA_W-1:0] position_out,
	input  wire logic [qds_pkg::DATA_W-1:0]        speed_out
);

	// held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position_out) && $stable(speed_out))
		else $error("result changed while stalled");

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	// a new result appears only as the block returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while busy");

	// set position passes through the result state to the output register when the output is free
	a_set_position: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == qds_pkg::CMD_SET) && !out_valid
		|=> ##1 out_valid && (position_out == $past(new_position, 2)))
		else $error("set position not returned");

endmodule

bind quadrature_decoder_speed qds_checker u_qds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.cmd          (cmd),
	.new_position (new_position),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.position_out (position_out),
	.speed_out    (speed_out)
);
`default_nettype wire
